/* rtl/core/mss_pkg.sv */
`timescale 1ns / 1ps

package mss_pkg;

    // Pattern storage is fixed by the register map: three 64-bit words
    localparam int PAT_BYTES = 24;
    localparam int PAT_BITS  = PAT_BYTES * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DISP_POS     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INSTR_LEN    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE  = 3'd7;

    // Register reset values
    localparam logic [4:0] RST_PATTERN_LEN = 5'd1;
    localparam logic [4:0] RST_DISP_POS    = 5'd3;
    localparam logic [7:0] RST_INSTR_LEN   = 8'd7;

    // Parameter defaults
    localparam int DEFAULT_MAX_PATTERN = 24;
    localparam int DEFAULT_COUNT_WIDTH = 32;

    // Per-cell compare status handed to the match logic
    typedef struct packed {
        logic       ok;        // byte matches or is a wildcard / unused
        logic [3:0] disp_sel;  // which displacement byte this cell supplies
    } cell_status_t;

endpackage

/* rtl/core/masked_signature_scan.sv */
`timescale 1ns / 1ps

// Masked byte-signature scanner.
// Input channel (in_valid/in_ready): one region byte per transaction, with
// last_byte marking the final byte of a region. Output channel
// (out_valid/out_ready): one transaction per region, sent after its last
// byte, carrying found, match_address and target_address (zero if no match).
// Configuration: cfg_write_en/cfg_index/cfg_data write one register per
// cycle; write only while no region result is outstanding.
// Throughput: one byte per cycle while in_ready is high. A row of MAX_PATTERN
// window cells shifts one byte per accepted byte and all cells compare against
// the pattern in parallel. A region's result passes a capture stage, a stage
// for base+offset and disp+length, then the final add into the output
// register. Results of up to three regions can be in flight.
// When the receiver stalls, results queue in those stages; in_ready drops
// only when all three are full. Reset clears the window, the byte count,
// the match state and the pipeline, and sets registers to their defaults.
module masked_signature_scan #(
    parameter int MAX_PATTERN = mss_pkg::DEFAULT_MAX_PATTERN,
    parameter int COUNT_WIDTH = mss_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [63:0]                    match_address,
    output logic [63:0]                    target_address
);
    import mss_pkg::*;

    localparam int LEN_CLOG = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W    = (LEN_CLOG > 5) ? LEN_CLOG : 5;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_mid_reg;
    logic [63:0] pattern_high_reg;
    logic [23:0] care_mask_reg;
    logic [4:0]  pattern_length_reg;
    logic [4:0]  disp_pos_reg;
    logic [7:0]  instr_len_reg;
    logic [63:0] region_base_reg;

    // Scan state
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   seen_reg;
    logic [COUNT_WIDTH-1:0] offset_reg;
    logic [31:0]            disp_reg;
    logic [63:0]            hit_base_reg;
    logic [7:0]             hit_ilen_reg;

    logic                   in_accept;
    logic                   result_ready;
    logic [LEN_W-1:0]       len_raw;
    logic [LEN_W-1:0]       eff_len;
    logic [PAT_BITS-1:0]    pattern;
    logic [7:0]             win_q   [MAX_PATTERN];
    logic [7:0]             win_d   [MAX_PATTERN];
    cell_status_t           status  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;
    logic                   hit_now;
    logic [31:0]            disp_now;
    logic [COUNT_WIDTH-1:0] offset_now;
    logic                   res_found;
    logic [COUNT_WIDTH-1:0] res_offset;
    logic [31:0]            res_disp;
    logic [63:0]            res_base;
    logic [7:0]             res_ilen;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = result_ready;
    assign pattern   = {pattern_high_reg, pattern_mid_reg, pattern_low_reg};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_mid_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= RST_PATTERN_LEN;
            disp_pos_reg       <= RST_DISP_POS;
            instr_len_reg      <= RST_INSTR_LEN;
            region_base_reg    <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                REG_PATTERN_MID:  pattern_mid_reg    <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                REG_CARE_MASK:    care_mask_reg      <= cfg_data[23:0];
                REG_PATTERN_LEN:  pattern_length_reg <= cfg_data[4:0];
                REG_DISP_POS:     disp_pos_reg       <= cfg_data[4:0];
                REG_INSTR_LEN:    instr_len_reg      <= cfg_data[7:0];
                REG_REGION_BASE:  region_base_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective pattern length: zero acts as one, clamp to the window depth
    always_comb
    begin
        len_raw = LEN_W'(pattern_length_reg);
        if (len_raw == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_raw > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = len_raw;
        end
    end

    // Window cells: cell 0 takes the incoming byte, cell k its left neighbor
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign win_d[k] = data_byte;
        end
        else
        begin : g_link
            assign win_d[k] = win_q[k-1];
        end

        mss_cell #(
            .INDEX (k),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (in_accept),
            .clear     (last_byte),
            .d_in      (win_d[k]),
            .q         (win_q[k]),
            .pattern   (pattern),
            .care_mask (care_mask_reg),
            .eff_len   (eff_len),
            .disp_pos  (disp_pos_reg),
            .status    (status[k])
        );

        assign cell_ok[k] = status[k].ok;
    end

    // Gather displacement bytes from the cells that hold them
    always_comb
    begin
        disp_now = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                if (status[k].disp_sel[m])
                begin
                    disp_now[8*m +: 8] = disp_now[8*m +: 8] | win_d[k];
                end
            end
        end
    end

    // Saturating byte count and first-match detect
    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign offset_now = count_next - COUNT_WIDTH'(eff_len);
    assign hit_now    = !seen_reg && (count_next >= COUNT_WIDTH'(eff_len)) && (&cell_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            count_reg <= last_byte ? '0 : count_next;
            seen_reg  <= last_byte ? 1'b0 : (seen_reg || hit_now);
        end
    end

    // Base and instruction length are taken as they stand at the match
    always_ff @(posedge clk)
    begin
        if (in_accept && hit_now)
        begin
            offset_reg   <= offset_now;
            disp_reg     <= disp_now;
            hit_base_reg <= region_base_reg;
            hit_ilen_reg <= instr_len_reg;
        end
    end

    // Region result handed to the address pipeline at the last byte
    assign res_found  = seen_reg || hit_now;
    assign res_offset = hit_now ? offset_now : offset_reg;
    assign res_disp   = hit_now ? disp_now : disp_reg;
    assign res_base   = hit_now ? region_base_reg : hit_base_reg;
    assign res_ilen   = hit_now ? instr_len_reg : hit_ilen_reg;

    mss_result #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_accept && last_byte),
        .load_ready     (result_ready),
        .found_in       (res_found),
        .offset_in      (res_offset),
        .disp_in        (res_disp),
        .region_base    (res_base),
        .instr_len      (res_ilen),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_address  (match_address),
        .target_address (target_address)
    );

`ifndef ASSERT_OFF
    // A finished region leaves no match state behind
    a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> !seen_reg)
        else $error("match state not cleared at region end");

    // Byte count is nonzero after every byte inside a region but the last
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !last_byte) |=> (count_reg != '0))
        else $error("byte count did not advance");

    // Input back-pressure only comes from a stalled, full output side
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output stall");

    // A miss reports zero addresses
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_address == 64'd0 && target_address == 64'd0))
        else $error("nonzero address on a miss");
`endif

endmodule

/* rtl/core/mss_cell.sv */
`timescale 1ns / 1ps

module mss_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic                       clear,
    input  logic [7:0]                 d_in,
    output logic [7:0]                 q,
    input  logic [mss_pkg::PAT_BITS-1:0]  pattern,
    input  logic [mss_pkg::PAT_BYTES-1:0] care_mask,
    input  logic [LEN_W-1:0]           eff_len,
    input  logic [4:0]                 disp_pos,
    output mss_pkg::cell_status_t      status
);
    import mss_pkg::*;

    localparam logic [LEN_W:0] K = (LEN_W+1)'(INDEX);

    logic [7:0]   byte_reg;
    logic [LEN_W:0] len_ext;
    logic [LEN_W:0] rel;
    logic [LEN_W:0] pos_ext;
    logic [LEN_W:0] disp_rel;
    logic         in_use;
    logic         cares;
    logic [31:0]  mask_ext;
    logic [255:0] pat_ext;
    logic [7:0]   pat_byte;

    // Window byte: takes d_in on every accepted transaction, or zero on a region's last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift_en)
        begin
            byte_reg <= clear ? 8'd0 : d_in;
        end
    end

    assign q = byte_reg;

    // Pattern slot seen by this cell after the shift: len-1-INDEX
    always_comb
    begin
        len_ext  = {1'b0, eff_len};
        in_use   = len_ext > K;
        rel      = len_ext - K - 1'b1;
        mask_ext = {{(32 - PAT_BYTES){1'b0}}, care_mask};
        pat_ext  = {{(256 - PAT_BITS){1'b0}}, pattern};
        pat_byte = pat_ext[{rel[4:0], 3'b000} +: 8];
        cares    = in_use && (rel < (LEN_W+1)'(PAT_BYTES)) && mask_ext[rel[4:0]];
        status.ok = !cares || (d_in == pat_byte);

        // Displacement byte m lives at pattern slot disp_pos+m
        pos_ext  = (LEN_W+1)'(disp_pos);
        disp_rel = rel - pos_ext;
        if (in_use && (rel >= pos_ext) && (disp_rel < (LEN_W+1)'(4)))
        begin
            status.disp_sel = 4'b0001 << disp_rel[1:0];
        end
        else
        begin
            status.disp_sel = 4'b0000;
        end
    end

endmodule

/* rtl/core/mss_result.sv */
`timescale 1ns / 1ps

module mss_result #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    output logic                   load_ready,
    input  logic                   found_in,
    input  logic [COUNT_WIDTH-1:0] offset_in,
    input  logic [31:0]            disp_in,
    input  logic [63:0]            region_base,
    input  logic [7:0]             instr_len,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [63:0]            match_address,
    output logic [63:0]            target_address
);
    logic                   s1_valid_reg;
    logic                   s1_found_reg;
    logic [COUNT_WIDTH-1:0] s1_offset_reg;
    logic [31:0]            s1_disp_reg;
    logic [63:0]            s1_base_reg;
    logic [7:0]             s1_ilen_reg;
    logic                   s2_valid_reg;
    logic                   s2_found_reg;
    logic [63:0]            s2_match_reg;
    logic [32:0]            s2_part_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [63:0]            match_reg;
    logic [63:0]            target_reg;
    logic                   out_free;
    logic                   s2_ready;

    // Stall chain: each stage moves when the one after it has room
    assign out_free   = !out_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || out_free;
    assign load_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_ready)
            begin
                s1_valid_reg <= load;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload: base+offset and disp+length in parallel, then the final add
    always_ff @(posedge clk)
    begin
        if (load_ready && load)
        begin
            s1_found_reg  <= found_in;
            s1_offset_reg <= offset_in;
            s1_disp_reg   <= disp_in;
            s1_base_reg   <= region_base;
            s1_ilen_reg   <= instr_len;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_found_reg <= s1_found_reg;
            s2_match_reg <= s1_base_reg + 64'(s1_offset_reg);
            s2_part_reg  <= 33'(s1_disp_reg) + 33'(s1_ilen_reg);
        end
        if (out_free && s2_valid_reg)
        begin
            found_reg  <= s2_found_reg;
            match_reg  <= s2_found_reg ? s2_match_reg : 64'd0;
            target_reg <= s2_found_reg ? (s2_match_reg + 64'(s2_part_reg)) : 64'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_address  = match_reg;
    assign target_address = target_reg;

endmodule
